>>> design/gpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_pkg
// Shared types and constants of the glyph path flattener: request payloads,
// command codes, register map and the MAC control group between the units.
// ----------------------------------------------------------------------------
package gpf_pkg;

  localparam int FRAC_BITS = 8;
  localparam int SCALE_W   = 20;
  localparam int COORD_W   = 16;
  localparam int VERT_W    = 32;
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 3;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 21;
  localparam int PROD_W    = 55;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

  typedef enum logic [1:0] {
    OP_MOVE   = 2'd0,
    OP_LINE   = 2'd1,
    OP_CURVE  = 2'd2,
    OP_IGNORE = 2'd3
  } gpf_op_e;

  typedef enum logic {
    REG_SCALE    = 1'b0,
    REG_X_OFFSET = 1'b1
  } gpf_reg_e;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } gpf_in_t;

  typedef struct packed {
    logic signed [VERT_W-1:0] vertex_x;
    logic signed [VERT_W-1:0] vertex_y;
    logic                     last;
  } gpf_out_t;

  typedef struct packed {
    logic [SCALE_W-1:0]       scale;
    logic signed [VERT_W-1:0] x_offset;
  } gpf_cfg_t;

  typedef struct packed {
    logic mul_en;
    logic acc_ld;
    logic acc_en;
  } gpf_mac_ctrl_t;

endpackage

>>> design/glyph_path_flattener_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_path_flattener_top
// Turns move, line and quadratic outline commands into scaled polygon
// vertices, flattening curves by de Casteljau from the last stored point.
// ----------------------------------------------------------------------------
//   channel  | signals                          | direction
//   ---------+----------------------------------+----------
//   in       | in_valid_i in_ready_o in_req_i   | request in
//   out      | out_valid_o out_ready_i out_req_o| vertex out
//   apb      | psel penable pwrite paddr ...    | config
//
// move or line: two scale multiplies between acceptance and the next ready
// curve: per vertex and axis three MAC terms, each a multiply and an accumulate,
//   a divider start and the reciprocal division
// ignored command: taken while idle, no vertex
// reset clears the stored last point to zero and the registers to defaults
// a stalled output holds the sequencer before it loads the next vertex
// ----------------------------------------------------------------------------
module glyph_path_flattener_top import gpf_pkg::*; #(
  parameter int SEGMENTS = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gpf_in_t            in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gpf_out_t           out_req_o
);

  localparam int DEN = SEGMENTS * SEGMENTS;
  localparam int DW  = $clog2(DEN + 1);
  localparam int UW  = VERT_W + DW;

  gpf_cfg_t                  cfg;
  gpf_mac_ctrl_t             mac_ctrl;
  logic signed [MUL_A_W-1:0] mac_a;
  logic [MUL_B_W-1:0]        mac_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  acc;
  logic                      div_start;
  logic [UW-1:0]             div_num;
  logic signed [VERT_W-1:0]  div_quot;
  logic                      div_done;

  gpf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gpf_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  gpf_div #(
    .DEN (DEN)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  gpf_seq #(
    .SEGMENTS (SEGMENTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o),
    .mac_ctrl_o  (mac_ctrl),
    .mac_a_o     (mac_a),
    .mac_b_o     (mac_b),
    .prod_i      (prod),
    .acc_i       (acc),
    .div_start_o (div_start),
    .div_num_o   (div_num),
    .div_quot_i  (div_quot),
    .div_done_i  (div_done)
  );

endmodule

>>> design/gpf_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_cfg_regs
// APB register file holding the scale factor and the horizontal offset.
// ----------------------------------------------------------------------------
module gpf_cfg_regs import gpf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output gpf_cfg_t           cfg_o
);

  logic               wr_en;
  gpf_reg_e           reg_sel;
  logic [SCALE_W-1:0] scale_q;
  logic [VERT_W-1:0]  x_offset_q;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = gpf_reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= SCALE_RESET;
      x_offset_q <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SCALE:    scale_q    <= pwdata[SCALE_W-1:0];
        REG_X_OFFSET: x_offset_q <= pwdata[VERT_W-1:0];
        default:      scale_q    <= scale_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCALE:    prdata = PDATA_W'(scale_q);
      REG_X_OFFSET: prdata = x_offset_q;
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.scale    = scale_q;
  assign cfg_o.x_offset = $signed(x_offset_q);

endmodule

>>> design/gpf_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_mac
// Shared multiply-accumulate unit: one registered signed-by-unsigned product
// and an accumulator fed from it.
// ----------------------------------------------------------------------------
module gpf_mac import gpf_pkg::*; (
  input  logic                      clk_i,
  input  gpf_mac_ctrl_t             ctrl_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0]        b_i,
  output logic signed [PROD_W-1:0]  prod_o,
  output logic signed [PROD_W-1:0]  acc_o
);

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [PROD_W-1:0] acc_q, acc_d;

  always_comb begin
    prod_d = prod_q;
    acc_d  = acc_q;
    if (ctrl_i.mul_en) begin
      prod_d = PROD_W'(a_i) * $signed(PROD_W'(b_i));
    end
    if (ctrl_i.acc_en) begin
      acc_d = ctrl_i.acc_ld ? prod_q : acc_q + prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

>>> design/gpf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_div
// Divider by a constant: a reciprocal multiply on the upper numerator bits, a
// second reciprocal pass on the remainder and a final compare and increment.
// Quotient and done are registered after the coarse, remainder, fine, remainder and fix steps.
// The numerator is biased non-negative and the quotient is known to fit 32 bits.
// ----------------------------------------------------------------------------
module gpf_div import gpf_pkg::*; #(
  parameter  int DEN = 25,
  localparam int DW  = $clog2(DEN + 1),
  localparam int UW  = VERT_W + DW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [UW-1:0]            num_i,
  output logic signed [VERT_W-1:0] quot_o,
  output logic                     done_o
);

  localparam int RCP_SH = DW + 19;
  localparam int RCP_W  = 21;
  localparam int MP_W   = VERT_W + RCP_W;
  localparam int R1_W   = DW + 14;
  localparam int Q2_W   = 16;

  localparam logic [RCP_W-1:0] RCP = RCP_W'((1 << RCP_SH) / DEN);

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_COARSE,
    DV_REM1,
    DV_FINE,
    DV_REM2,
    DV_FIX
  } div_state_e;

  div_state_e        state_q, state_d;
  logic [UW-1:0]     num_q, num_d;
  logic [MP_W-1:0]   prod_q, prod_d;
  logic [VERT_W-1:0] q1_q, q1_d;
  logic [R1_W-1:0]   r1_q, r1_d;
  logic [Q2_W-1:0]   q2_q, q2_d;
  logic [DW:0]       r2_q, r2_d;
  logic [VERT_W-1:0] quo_q, quo_d;
  logic              done_q, done_d;

  logic [VERT_W-1:0] mul_a;
  logic [VERT_W-1:0] q1_est;
  logic [Q2_W-1:0]   q2_est;
  logic [UW-1:0]     r1_full;
  logic [R1_W-1:0]   r2_full;

  always_comb begin
    mul_a   = (state_q == DV_FINE) ? VERT_W'(r1_q) : num_q[UW-1:DW];
    q1_est  = prod_q[RCP_SH-DW +: VERT_W];
    q2_est  = prod_q[RCP_SH +: Q2_W];
    r1_full = num_q - UW'(q1_est) * UW'(DEN);
    r2_full = r1_q - R1_W'(q2_est) * R1_W'(DEN);

    state_d = state_q;
    num_d   = num_q;
    prod_d  = prod_q;
    q1_d    = q1_q;
    r1_d    = r1_q;
    q2_d    = q2_q;
    r2_d    = r2_q;
    quo_d   = quo_q;
    done_d  = 1'b0;

    case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          num_d   = num_i;
          state_d = DV_COARSE;
        end
      end
      DV_COARSE: begin
        prod_d  = MP_W'(mul_a) * MP_W'(RCP);
        state_d = DV_REM1;
      end
      DV_REM1: begin
        q1_d    = q1_est;
        r1_d    = r1_full[R1_W-1:0];
        state_d = DV_FINE;
      end
      DV_FINE: begin
        prod_d  = MP_W'(mul_a) * MP_W'(RCP);
        state_d = DV_REM2;
      end
      DV_REM2: begin
        q2_d    = q2_est;
        r2_d    = r2_full[DW:0];
        state_d = DV_FIX;
      end
      DV_FIX: begin
        quo_d   = q1_q + VERT_W'(q2_q) + VERT_W'(r2_q >= (DW+1)'(DEN));
        done_d  = 1'b1;
        state_d = DV_IDLE;
      end
      default: begin
        state_d = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      num_q   <= '0;
      prod_q  <= '0;
      q1_q    <= '0;
      r1_q    <= '0;
      q2_q    <= '0;
      r2_q    <= '0;
      quo_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      num_q   <= num_d;
      prod_q  <= prod_d;
      q1_q    <= q1_d;
      r1_q    <= r1_d;
      q2_q    <= q2_d;
      r2_q    <= r2_d;
      quo_q   <= quo_d;
      done_q  <= done_d;
    end
  end

  // remove the bias of 2^31 on the quotient
  assign quot_o = $signed({~quo_q[VERT_W-1], quo_q[VERT_W-2:0]});
  assign done_o = done_q;

endmodule

>>> design/gpf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_seq
// Command sequencer: scales the coordinates, drives the shared MAC and the
// divider through the curve weights and loads the vertex output register.
// ----------------------------------------------------------------------------
module gpf_seq import gpf_pkg::*; #(
  parameter  int SEGMENTS = 5,
  localparam int DEN      = SEGMENTS * SEGMENTS,
  localparam int DW       = $clog2(DEN + 1),
  localparam int UW       = VERT_W + DW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gpf_cfg_t                  cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  gpf_in_t                   in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output gpf_out_t                  out_req_o,
  output gpf_mac_ctrl_t             mac_ctrl_o,
  output logic signed [MUL_A_W-1:0] mac_a_o,
  output logic [MUL_B_W-1:0]        mac_b_o,
  input  logic signed [PROD_W-1:0]  prod_i,
  input  logic signed [PROD_W-1:0]  acc_i,
  output logic                      div_start_o,
  output logic [UW-1:0]             div_num_o,
  input  logic signed [VERT_W-1:0]  div_quot_i,
  input  logic                      div_done_i
);

  localparam int SEG_W = $clog2(SEGMENTS + 1);
  localparam int SHIFT = 16 - FRAC_BITS;
  localparam int RND   = (SHIFT > 0) ? (2 ** (SHIFT - 1)) : 0;
  localparam int HALF  = DEN / 2;

  localparam logic [1:0] TERM_PREV = 2'd0;
  localparam logic [1:0] TERM_CTRL = 2'd1;
  localparam logic [1:0] TERM_END  = 2'd2;

  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] SAT_MIN = PROD_W'(-64'sd2147483648);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMUL,
    ST_SWB,
    ST_LOUT,
    ST_CMUL,
    ST_CACC,
    ST_CSTART,
    ST_CDIV,
    ST_COUT
  } state_e;

  typedef enum logic {
    AXIS_X,
    AXIS_Y
  } axis_e;

  function automatic logic signed [VERT_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [VERT_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[VERT_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[VERT_W-1:0];
    end else begin
      r = v[VERT_W-1:0];
    end
    return r;
  endfunction

  // de casteljau weights (S-i)^2, 2i(S-i), i^2
  function automatic logic [DW-1:0] weight(input logic [SEG_W-1:0] i, input logic [1:0] t);
    int ii;
    int ri;
    int w;
    ii = int'(i);
    ri = SEGMENTS - ii;
    case (t)
      TERM_PREV: w = ri * ri;
      TERM_CTRL: w = 2 * ii * ri;
      TERM_END:  w = ii * ii;
      default:   w = 0;
    endcase
    return DW'(w);
  endfunction

  state_e                   state_q, state_d;
  axis_e                    axis_q, axis_d;
  logic [1:0]               k_q, k_d;
  logic [1:0]               t_q, t_d;
  logic [SEG_W-1:0]         i_q, i_d;
  gpf_in_t                  req_q, req_d;
  logic signed [VERT_W-1:0] p0x_q, p0x_d, p0y_q, p0y_d;
  logic signed [VERT_W-1:0] p1x_q, p1x_d, p1y_q, p1y_d;
  logic signed [VERT_W-1:0] p2x_q, p2x_d, p2y_q, p2y_d;
  logic signed [VERT_W-1:0] vx_q, vx_d, vy_q, vy_d;
  logic                     out_valid_q, out_valid_d;
  gpf_out_t                 out_q, out_d;

  logic                     out_free;
  logic signed [16:0]       scl_coord;
  logic signed [VERT_W-1:0] crv_pt;
  logic signed [PROD_W-1:0] scaled;
  logic signed [VERT_W-1:0] scaled_sat;
  logic signed [VERT_W-1:0] x_src;
  logic signed [VERT_W:0]   x_sum;
  logic signed [PROD_W-1:0] num_full;
  logic                     is_curve;

  assign out_free = !out_valid_q || out_ready_i;
  assign is_curve = gpf_op_e'(req_q.op) == OP_CURVE;

  always_comb begin
    case (k_q)
      2'd0:    scl_coord = 17'(req_q.ax);
      2'd1:    scl_coord = -17'(req_q.ay);
      2'd2:    scl_coord = 17'(req_q.bx);
      default: scl_coord = -17'(req_q.by);
    endcase
  end

  always_comb begin
    case (t_q)
      TERM_PREV: crv_pt = (axis_q == AXIS_X) ? p0x_q : p0y_q;
      TERM_CTRL: crv_pt = (axis_q == AXIS_X) ? p1x_q : p1y_q;
      TERM_END:  crv_pt = (axis_q == AXIS_X) ? p2x_q : p2y_q;
      default:   crv_pt = '0;
    endcase
  end

  // round half up to the vertex fraction, then clamp
  assign scaled     = (prod_i + PROD_W'(RND)) >>> SHIFT;
  assign scaled_sat = sat32(scaled);

  assign x_src = (state_q == ST_LOUT) ? p1x_q : vx_q;
  assign x_sum = (VERT_W+1)'(x_src) + (VERT_W+1)'(cfg_i.x_offset);

  // biased numerator: floor((acc + den/2) / den) + 2^31 as a plain quotient
  assign num_full  = acc_i + PROD_W'(HALF) + (PROD_W'(DEN) <<< (VERT_W - 1));
  assign div_num_o = num_full[UW-1:0];

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    k_d         = k_q;
    t_d         = t_q;
    i_d         = i_q;
    req_d       = req_q;
    p0x_d       = p0x_q;
    p0y_d       = p0y_q;
    p1x_d       = p1x_q;
    p1y_d       = p1y_q;
    p2x_d       = p2x_q;
    p2y_d       = p2y_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mac_ctrl_o  = '0;
    mac_a_o     = '0;
    mac_b_o     = '0;
    div_start_o = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          k_d   = '0;
          if (gpf_op_e'(in_req_i.op) != OP_IGNORE) begin
            state_d = ST_SMUL;
          end
        end
      end
      ST_SMUL: begin
        mac_ctrl_o.mul_en = 1'b1;
        mac_a_o           = MUL_A_W'(scl_coord);
        mac_b_o           = MUL_B_W'(cfg_i.scale);
        state_d           = ST_SWB;
      end
      ST_SWB: begin
        case (k_q)
          2'd0:    p1x_d = scaled_sat;
          2'd1:    p1y_d = scaled_sat;
          2'd2:    p2x_d = scaled_sat;
          default: p2y_d = scaled_sat;
        endcase
        if (is_curve && k_q == 2'd3) begin
          i_d     = SEG_W'(1);
          t_d     = TERM_PREV;
          axis_d  = AXIS_X;
          state_d = ST_CMUL;
        end else if (!is_curve && k_q == 2'd1) begin
          state_d = ST_LOUT;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_SMUL;
        end
      end
      ST_LOUT: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.vertex_x = sat32(PROD_W'(x_sum));
          out_d.vertex_y = p1y_q;
          out_d.last     = 1'b1;
          p0x_d          = p1x_q;
          p0y_d          = p1y_q;
          state_d        = ST_IDLE;
        end
      end
      ST_CMUL: begin
        mac_ctrl_o.mul_en = 1'b1;
        mac_a_o           = MUL_A_W'(crv_pt);
        mac_b_o           = MUL_B_W'(weight(i_q, t_q));
        state_d           = ST_CACC;
      end
      ST_CACC: begin
        mac_ctrl_o.acc_en = 1'b1;
        mac_ctrl_o.acc_ld = (t_q == TERM_PREV);
        if (t_q == TERM_END) begin
          state_d = ST_CSTART;
        end else begin
          t_d     = t_q + 2'd1;
          state_d = ST_CMUL;
        end
      end
      ST_CSTART: begin
        div_start_o = 1'b1;
        state_d     = ST_CDIV;
      end
      ST_CDIV: begin
        if (div_done_i) begin
          t_d = TERM_PREV;
          if (axis_q == AXIS_X) begin
            vx_d    = div_quot_i;
            axis_d  = AXIS_Y;
            state_d = ST_CMUL;
          end else begin
            vy_d    = div_quot_i;
            state_d = ST_COUT;
          end
        end
      end
      ST_COUT: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.vertex_x = sat32(PROD_W'(x_sum));
          out_d.vertex_y = vy_q;
          out_d.last     = (i_q == SEG_W'(SEGMENTS));
          if (i_q == SEG_W'(SEGMENTS)) begin
            p0x_d   = p2x_q;
            p0y_d   = p2y_q;
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            t_d     = TERM_PREV;
            axis_d  = AXIS_X;
            state_d = ST_CMUL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AXIS_X;
      k_q         <= '0;
      t_q         <= TERM_PREV;
      i_q         <= '0;
      req_q       <= '0;
      p0x_q       <= '0;
      p0y_q       <= '0;
      p1x_q       <= '0;
      p1y_q       <= '0;
      p2x_q       <= '0;
      p2y_q       <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      k_q         <= k_d;
      t_q         <= t_d;
      i_q         <= i_d;
      req_q       <= req_d;
      p0x_q       <= p0x_d;
      p0y_q       <= p0y_d;
      p1x_q       <= p1x_d;
      p1y_q       <= p1y_d;
      p2x_q       <= p2x_d;
      p2y_q       <= p2y_d;
      vx_q        <= vx_d;
      vy_q        <= vy_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

`ifndef SYNTHESIS
  curve_starts_scaling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && gpf_op_e'(in_req_i.op) == OP_CURVE) |=> (state_q == ST_SMUL))
    else $error("curve request did not start scaling");

  segment_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COUT) |-> (i_q != '0 && i_q <= SEG_W'(SEGMENTS)))
    else $error("segment index out of range");

  div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_i |-> (state_q == ST_CDIV))
    else $error("divider finished outside of its wait state");
`endif

endmodule
